FILE: hw/rtl/bsit_pkg.sv
package bsit_pkg;

    // Shape kind codes. The fourth code has no meaning and is handled as no shape.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_SPHERE = 2'd2
    } kind_t;

    // Which test an item goes through.
    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_BOX_BOX = 2'd1,
        MODE_SPH_SPH = 2'd2,
        MODE_BOX_SPH = 2'd3
    } mode_t;

    localparam int KIND_W   = 2;
    localparam int CENTER_W = 16;
    localparam int EXTENT_W = 15;
    localparam int AXES     = 3;
    // Magnitude of a center difference, and sum of two extents.
    localparam int DIST_W   = CENTER_W;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int SUM_W    = SQ_W + 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_OWN_KIND     = 3'd0;
    localparam logic [2:0] REG_OWN_CENTER_X = 3'd1;
    localparam logic [2:0] REG_OWN_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_OWN_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_OWN_EXTENT_X = 3'd4;
    localparam logic [2:0] REG_OWN_EXTENT_Y = 3'd5;
    localparam logic [2:0] REG_OWN_EXTENT_Z = 3'd6;

    localparam logic [EXTENT_W-1:0] EXTENT_RESET = 15'd128;

    typedef struct packed {
        logic [KIND_W-1:0]                  kind;
        logic [AXES-1:0][CENTER_W-1:0]      center;
        logic [AXES-1:0][EXTENT_W-1:0]      extent;
    } shape_t;

endpackage

FILE: hw/rtl/bsit_if.sv
interface bsit_query_if;
    logic                valid;
    logic                ready;
    logic [1:0]          query_kind;
    logic signed [15:0]  query_center_x;
    logic signed [15:0]  query_center_y;
    logic signed [15:0]  query_center_z;
    logic [14:0]         query_extent_x;
    logic [14:0]         query_extent_y;
    logic [14:0]         query_extent_z;

    modport source (
        output valid, query_kind, query_center_x, query_center_y, query_center_z,
               query_extent_x, query_extent_y, query_extent_z,
        input  ready
    );
    modport sink (
        input  valid, query_kind, query_center_x, query_center_y, query_center_z,
               query_extent_x, query_extent_y, query_extent_z,
        output ready
    );
endinterface

interface bsit_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

FILE: hw/rtl/bsit_cfg.sv
module bsit_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bsit_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bsit_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bsit_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output bsit_pkg::shape_t                  own_shape
);
    import bsit_pkg::*;

    logic [KIND_W-1:0]             kind_reg;
    logic [AXES-1:0][CENTER_W-1:0] center_reg;
    logic [AXES-1:0][EXTENT_W-1:0] extent_reg;
    logic                          wr_en;
    logic [2:0]                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_NONE;
            center_reg <= '0;
            extent_reg <= {AXES{EXTENT_RESET}};
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OWN_KIND:     kind_reg      <= pwdata[KIND_W-1:0];
                REG_OWN_CENTER_X: center_reg[0] <= pwdata[CENTER_W-1:0];
                REG_OWN_CENTER_Y: center_reg[1] <= pwdata[CENTER_W-1:0];
                REG_OWN_CENTER_Z: center_reg[2] <= pwdata[CENTER_W-1:0];
                REG_OWN_EXTENT_X: extent_reg[0] <= pwdata[EXTENT_W-1:0];
                REG_OWN_EXTENT_Y: extent_reg[1] <= pwdata[EXTENT_W-1:0];
                REG_OWN_EXTENT_Z: extent_reg[2] <= pwdata[EXTENT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OWN_KIND:     prdata = {{(APB_DATA_W-KIND_W){1'b0}}, kind_reg};
            REG_OWN_CENTER_X: prdata = {{(APB_DATA_W-CENTER_W){center_reg[0][CENTER_W-1]}},
                                        center_reg[0]};
            REG_OWN_CENTER_Y: prdata = {{(APB_DATA_W-CENTER_W){center_reg[1][CENTER_W-1]}},
                                        center_reg[1]};
            REG_OWN_CENTER_Z: prdata = {{(APB_DATA_W-CENTER_W){center_reg[2][CENTER_W-1]}},
                                        center_reg[2]};
            REG_OWN_EXTENT_X: prdata = {{(APB_DATA_W-EXTENT_W){1'b0}}, extent_reg[0]};
            REG_OWN_EXTENT_Y: prdata = {{(APB_DATA_W-EXTENT_W){1'b0}}, extent_reg[1]};
            REG_OWN_EXTENT_Z: prdata = {{(APB_DATA_W-EXTENT_W){1'b0}}, extent_reg[2]};
            default:          prdata = '0;
        endcase
    end

    assign own_shape.kind   = kind_reg;
    assign own_shape.center = center_reg;
    assign own_shape.extent = extent_reg;

endmodule

FILE: hw/rtl/bsit_core.sv
module bsit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  bsit_pkg::shape_t  own_shape,
    bsit_query_if.sink        query,
    bsit_result_if.source     result
);
    import bsit_pkg::*;

    // Stage valids and advance enables; each stage moves when empty or when
    // the stage after it moves.
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv_out;

    // Stage 1: registered query.
    shape_t q_reg;

    // Stage 2: per-axis distances and the radius.
    mode_t                       mode2_reg, mode2_next;
    logic                        bb2_reg, bb2_next;
    logic [AXES-1:0][DIST_W-1:0] val2_reg, val2_next;
    logic [DIST_W-1:0]           rad2_reg, rad2_next;

    // Stage 3: squares.
    mode_t                       mode3_reg;
    logic                        bb3_reg;
    logic [AXES-1:0][SQ_W-1:0]   sq3_reg;
    logic [SQ_W-1:0]             rsq3_reg;

    // Output stage.
    logic hit_reg, hit_next;

    logic                        own_box, own_sph, q_box, q_sph;
    logic [AXES-1:0]             bb_ok;
    logic signed [CENTER_W:0]    diff     [AXES];
    logic [DIST_W-1:0]           absd     [AXES];
    logic [DIST_W-1:0]           box_ext  [AXES];
    logic [DIST_W-1:0]           ext_sum  [AXES];
    logic [DIST_W-1:0]           gap      [AXES];
    logic [SUM_W-1:0]            sq_sum;
    logic [SUM_W-1:0]            rsq_ext;

    assign adv_out     = !out_valid_reg || result.ready;
    assign adv3        = !v3_reg || adv_out;
    assign adv2        = !v2_reg || adv3;
    assign adv1        = !v1_reg || adv2;
    assign query.ready = adv1;

    assign result.valid = out_valid_reg;
    assign result.hit   = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= query.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv_out)
                out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            q_reg.kind      <= query.query_kind;
            q_reg.center[0] <= query.query_center_x;
            q_reg.center[1] <= query.query_center_y;
            q_reg.center[2] <= query.query_center_z;
            q_reg.extent[0] <= query.query_extent_x;
            q_reg.extent[1] <= query.query_extent_y;
            q_reg.extent[2] <= query.query_extent_z;
        end
        if (adv2)
        begin
            mode2_reg <= mode2_next;
            bb2_reg   <= bb2_next;
            val2_reg  <= val2_next;
            rad2_reg  <= rad2_next;
        end
        if (adv3)
        begin
            mode3_reg <= mode2_reg;
            bb3_reg   <= bb2_reg;
            for (int i = 0; i < AXES; i++)
                sq3_reg[i] <= val2_reg[i] * val2_reg[i];
            rsq3_reg  <= rad2_reg * rad2_reg;
        end
        if (adv_out)
            hit_reg <= hit_next;
    end

    // Stage 2 logic: pick the test, then per axis the center distance,
    // the box-box overlap and the gap outside the box.
    always_comb
    begin
        own_box = (own_shape.kind == KIND_BOX);
        own_sph = (own_shape.kind == KIND_SPHERE);
        q_box   = (q_reg.kind == KIND_BOX);
        q_sph   = (q_reg.kind == KIND_SPHERE);

        if (own_box && q_box)
            mode2_next = MODE_BOX_BOX;
        else if (own_sph && q_sph)
            mode2_next = MODE_SPH_SPH;
        else if ((own_box && q_sph) || (own_sph && q_box))
            mode2_next = MODE_BOX_SPH;
        else
            mode2_next = MODE_NONE;

        for (int i = 0; i < AXES; i++)
        begin
            diff[i] = $signed({own_shape.center[i][CENTER_W-1], own_shape.center[i]})
                    - $signed({q_reg.center[i][CENTER_W-1], q_reg.center[i]});
            absd[i] = diff[i][CENTER_W] ? DIST_W'(-diff[i]) : diff[i][DIST_W-1:0];
            ext_sum[i] = {1'b0, own_shape.extent[i]} + {1'b0, q_reg.extent[i]};
            bb_ok[i]   = absd[i] < ext_sum[i];
            box_ext[i] = own_box ? {1'b0, own_shape.extent[i]} : {1'b0, q_reg.extent[i]};
            gap[i]     = (absd[i] > box_ext[i]) ? absd[i] - box_ext[i] : '0;
            val2_next[i] = (mode2_next == MODE_SPH_SPH) ? absd[i] : gap[i];
        end
        bb2_next = &bb_ok;

        if (mode2_next == MODE_SPH_SPH)
            rad2_next = ext_sum[0];
        else if (own_box)
            rad2_next = {1'b0, q_reg.extent[0]};
        else
            rad2_next = {1'b0, own_shape.extent[0]};
    end

    // Output stage: box-box overlap, or sum of squares vs squared radius.
    always_comb
    begin
        sq_sum  = SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
        rsq_ext = SUM_W'(rsq3_reg);
        case (mode3_reg)
            MODE_BOX_BOX: hit_next = bb3_reg;
            MODE_SPH_SPH: hit_next = sq_sum < rsq_ext;
            MODE_BOX_SPH: hit_next = sq_sum <= rsq_ext;
            default:      hit_next = 1'b0;
        endcase
    end

endmodule

FILE: hw/rtl/box_sphere_intersect_test_unit.sv
// Box/sphere intersection test against one reference shape held in registers.
// Throughput: one query per cycle through a four-register pipeline
// (input, distance, squaring, compare); the hit flag comes from the compare
// register, and a stalled result backs up stage by stage.
// Reset: rst_n is asynchronous and empties the pipeline; the reference shape
// returns to kind none, centers zero and extents 128.
module box_sphere_intersect_test_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bsit_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bsit_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bsit_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    bsit_query_if.sink                        query,
    bsit_result_if.source                     result
);
    import bsit_pkg::*;

    shape_t own_shape;

    bsit_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .own_shape (own_shape)
    );

    bsit_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .own_shape (own_shape),
        .query     (query),
        .result    (result)
    );

endmodule

FILE: hw/rtl/bsit_checker.sv
module bsit_checker (
    input logic clk,
    input logic rst_n,
    input logic q_valid,
    input logic q_ready,
    input logic r_valid,
    input logic r_ready,
    input logic r_hit
);
    localparam int PIPE_DEPTH = 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_xfer, out_xfer;

    assign in_xfer  = q_valid & q_ready;
    assign out_xfer = r_valid & r_ready;
    assign cnt_next = cnt_reg + CNT_W'(in_xfer) - CNT_W'(out_xfer);

    // Items taken in but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (cnt_reg != '0))
        else $error("result offered with no query outstanding");

    a_bounded_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more queries outstanding than pipeline stages");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> q_ready)
        else $error("query not accepted while pipeline is empty");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> (r_valid && $stable(r_hit)))
        else $error("stalled result changed or dropped");

endmodule

bind box_sphere_intersect_test_unit bsit_checker u_bsit_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (query.valid),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_hit   (result.hit)
);
